@@ src/matrix_keypad_debounce_scanner_top_macros.svh @@
// ----------------------------------------------------------------------------
// Keypad scanner assertion macros
// Shorthand for the concurrent checks used in the keypad scanner modules.
// Each macro expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MATRIX_KEYPAD_DEBOUNCE_SCANNER_TOP_MACROS_SVH
`define MATRIX_KEYPAD_DEBOUNCE_SCANNER_TOP_MACROS_SVH

// Same-cycle implication, checked at every clock outside reset
`define KPS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keypad scanner check failed");

// Next-cycle implication, checked at every clock outside reset
`define KPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keypad scanner check failed");

`endif

@@ src/kps_pkg.sv @@
// ----------------------------------------------------------------------------
// Keypad scanner package
// Shared types, constants and the fixed key character map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kps_pkg;

	localparam int ROWS     = 4;
	localparam int COLUMNS  = 4;
	localparam int MATRIX_W = 16;
	localparam int CNT_W    = 16;
	localparam int CFG_W    = 16;
	localparam int IDX_W    = 4;
	localparam int CHAR_W   = 8;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Reset values of the timing registers
	localparam logic [CFG_W-1:0] PRESS_TICKS_RST   = 16'd100;
	localparam logic [CFG_W-1:0] POLL_TICKS_RST    = 16'd20;
	localparam logic [CFG_W-1:0] RELEASE_TICKS_RST = 16'd150;

	// Register indexes of the configuration port
	typedef enum logic [1:0] {
		CFG_PRESS_TICKS   = 2'd0,
		CFG_POLL_TICKS    = 2'd1,
		CFG_RELEASE_TICKS = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_PRESS   = 2'd1,
		PH_HELD    = 2'd2,
		PH_RELEASE = 2'd3
	} phase_t;

	typedef struct packed {
		logic [MATRIX_W-1:0] key_matrix;
		logic                tick;
	} in_word_t;

	typedef struct packed {
		logic              key_valid;
		logic [IDX_W-1:0]  key_index;
		logic [CHAR_W-1:0] key_char;
		logic              busy_res;
	} out_word_t;

	typedef struct packed {
		logic [CFG_W-1:0] press_ticks;
		logic [CFG_W-1:0] poll_ticks;
		logic [CFG_W-1:0] release_ticks;
	} cfg_t;

	// Scan results handed from the encoder to the controller
	typedef struct packed {
		logic [ROWS-1:0]   row_low;
		logic              found;
		logic [IDX_W-1:0]  key_index;
		logic [CHAR_W-1:0] key_char;
	} scan_t;

	// Character printed on the key at row r, column c; 0 off the 4x4 face
	function automatic logic [CHAR_W-1:0] key_char_map(input logic [3:0] r,
			input logic [3:0] c);
		logic [CHAR_W-1:0] ch;
		ch = '0;
		if (r < 4'd4 && c < 4'd4) begin
			unique case ({r[1:0], c[1:0]})
				4'h0: ch = "1";
				4'h1: ch = "2";
				4'h2: ch = "3";
				4'h3: ch = "A";
				4'h4: ch = "4";
				4'h5: ch = "5";
				4'h6: ch = "6";
				4'h7: ch = "B";
				4'h8: ch = "7";
				4'h9: ch = "8";
				4'hA: ch = "9";
				4'hB: ch = "C";
				4'hC: ch = "*";
				4'hD: ch = "0";
				4'hE: ch = "#";
				4'hF: ch = "D";
				default: ch = '0;
			endcase
		end
		return ch;
	endfunction

endpackage

@@ src/kps_scan.sv @@
// ----------------------------------------------------------------------------
// Keypad matrix encoder
// Row-low vector and column-major first-key search with character lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kps_scan (
	input  logic [kps_pkg::MATRIX_W-1:0] key_matrix,
	output kps_pkg::scan_t               scan
);
	import kps_pkg::*;

	always_comb begin
		// Mark each row that has any pressed key
		scan.row_low = '0;
		for (int r = 0; r < ROWS; r++) begin
			for (int c = 0; c < COLUMNS; c++) begin
				if (r * COLUMNS + c < MATRIX_W) begin
					if (key_matrix[r * COLUMNS + c]) begin
						scan.row_low[r] = 1'b1;
					end
				end
			end
		end

		// Walk backward so the first key in column-major order wins
		scan.found     = 1'b0;
		scan.key_index = '0;
		scan.key_char  = '0;
		for (int c = COLUMNS - 1; c >= 0; c--) begin
			for (int r = ROWS - 1; r >= 0; r--) begin
				if (r * COLUMNS + c < MATRIX_W) begin
					if (key_matrix[r * COLUMNS + c]) begin
						scan.found     = 1'b1;
						scan.key_index = IDX_W'(r * COLUMNS + c);
						scan.key_char  = key_char_map(4'(r), 4'(c));
					end
				end
			end
		end
	end

endmodule

@@ src/kps_ctrl.sv @@
// ----------------------------------------------------------------------------
// Keypad debounce controller
// Wake detect, tick counter and phase sequencing for one word per cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "matrix_keypad_debounce_scanner_top_macros.svh"

module kps_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic               tick,
	input  kps_pkg::scan_t     scan,
	input  kps_pkg::cfg_t      cfg,
	output kps_pkg::out_word_t res_next
);
	import kps_pkg::*;

	phase_t            phase_q;
	phase_t            phase_eff;
	phase_t            phase_d;
	logic [CNT_W-1:0]  elapsed_q;
	logic [CNT_W-1:0]  elapsed_inc;
	logic [CNT_W-1:0]  elapsed_eff;
	logic [CNT_W-1:0]  elapsed_d;
	logic [ROWS-1:0]   prev_row_low_q;
	logic              wake;
	logic              press_done;

	// Saturating tick count, then the wake check restarts it
	always_comb begin
		elapsed_inc = (tick && elapsed_q != CNT_MAX) ? elapsed_q + 1'b1 : elapsed_q;
		wake        = (phase_q == PH_IDLE) && ((scan.row_low & ~prev_row_low_q) != '0);
		phase_eff   = wake ? PH_PRESS : phase_q;
		elapsed_eff = wake ? '0 : elapsed_inc;
		press_done  = (phase_eff == PH_PRESS) && (elapsed_eff >= cfg.press_ticks);
	end

	// Next phase and count
	always_comb begin
		phase_d   = phase_eff;
		elapsed_d = elapsed_eff;
		unique case (phase_eff)
			PH_IDLE: begin
				phase_d = PH_IDLE;
			end
			PH_PRESS: begin
				if (press_done) begin
					if (scan.found) begin
						phase_d   = PH_HELD;
						elapsed_d = '0;
					end else begin
						phase_d = PH_IDLE;
					end
				end
			end
			PH_HELD: begin
				if (elapsed_eff >= cfg.poll_ticks) begin
					elapsed_d = '0;
					if (scan.row_low == '0) begin
						phase_d = PH_RELEASE;
					end
				end
			end
			PH_RELEASE: begin
				if (elapsed_eff >= cfg.release_ticks) begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// Result word for this step
	always_comb begin
		res_next.key_valid = press_done && scan.found;
		res_next.key_index = res_next.key_valid ? scan.key_index : '0;
		res_next.key_char  = res_next.key_valid ? scan.key_char : '0;
		res_next.busy_res  = (phase_d != PH_IDLE);
	end

	// Commit state when a word moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			elapsed_q      <= '0;
			prev_row_low_q <= '0;
		end else if (advance) begin
			phase_q        <= phase_d;
			elapsed_q      <= elapsed_d;
			prev_row_low_q <= scan.row_low;
		end
	end

	`KPS_ASSERT_IMPL(a_report_enters_held, res_next.key_valid, phase_d == PH_HELD)
	`KPS_ASSERT_IMPL(a_held_exits_to_release, phase_q == PH_HELD,
		phase_d == PH_HELD || phase_d == PH_RELEASE)
	`KPS_ASSERT_IMPL(a_held_entry_reports,
		phase_q != PH_HELD && phase_d == PH_HELD, res_next.key_valid)
	`KPS_ASSERT_NEXT(a_state_holds_when_stalled, !advance,
		phase_q == $past(phase_q) && elapsed_q == $past(elapsed_q))

endmodule

@@ src/matrix_keypad_debounce_scanner_top.sv @@
// A word accepted into the input register passes the encoder and controller logic into
// the result register, which offers it at the output. Throughput: one word per cycle
// unless the output stalls; the input register, the encoder and controller logic and
// the result register form a two-stage flow-controlled pipeline.
// Reset: arst_n clears the phase to idle, the tick count and the row history,
// and loads the timing registers with 100, 20 and 150 ticks. No clearing pass.
// ----------------------------------------------------------------------------
// Keypad debounce scanner top level
// Input register, matrix encoder, debounce controller and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_keypad_debounce_scanner_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  kps_pkg::in_word_t         item,
	output logic                      result_valid,
	input  logic                      result_stall,
	output kps_pkg::out_word_t        result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [kps_pkg::CFG_W-1:0] cfg_data
);
	import kps_pkg::*;

	logic      valid_s1;
	in_word_t  item_s1;
	logic      valid_s2;
	out_word_t result_s2;
	logic      advance;
	cfg_t      cfg_q;
	scan_t     scan;
	out_word_t res_next;

	// Move stage 1 on when the result register is free or being drained
	assign advance      = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall   = valid_s1 && !advance;
	assign result_valid = valid_s2;
	assign result       = result_s2;
	assign cfg_ready    = 1'b1;

	// Timing registers; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_ticks   <= PRESS_TICKS_RST;
			cfg_q.poll_ticks    <= POLL_TICKS_RST;
			cfg_q.release_ticks <= RELEASE_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_PRESS_TICKS:   cfg_q.press_ticks   <= cfg_data;
				CFG_POLL_TICKS:    cfg_q.poll_ticks    <= cfg_data;
				CFG_RELEASE_TICKS: cfg_q.release_ticks <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (advance) begin
			result_s2 <= res_next;
		end
	end

	kps_scan u_scan (
		.key_matrix (item_s1.key_matrix),
		.scan       (scan)
	);

	kps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.tick     (item_s1.tick),
		.scan     (scan),
		.cfg      (cfg_q),
		.res_next (res_next)
	);

endmodule
